/* hw/rtl/sarc_pkg.sv */
// Shared types and constants for the set-associative row cache.
// No dependencies; imported by sarc_hash, set_assoc_row_cache_top, row_cache_checker and tb.
package sarc_pkg;

  localparam int MAX_SETS  = 1024;
  localparam int NUM_WAYS  = 8;              // power of two: victim pointer wraps naturally
  localparam int ROW_SIZE_BYTES = 8;
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SLOTS     = MAX_SETS * NUM_WAYS;
  localparam int SLOT_W    = SET_W + WAY_W;
  localparam int KEY_W     = 32;
  localparam int ROW_W     = 64;
  localparam int CFG_W     = 11;
  localparam int CNT_W     = 14;

  localparam int HASH_W     = 64;
  localparam int HASH_SHIFT = 29;
  localparam int RADIX_BITS = 4;
  localparam int DIGITS     = HASH_W / RADIX_BITS;
  localparam int DIG_W      = $clog2(DIGITS);

  localparam logic [HASH_W-1:0] HASH_MUL  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KEY_W-1:0]  EMPTY_KEY = 32'hFFFF_FFFF;
  localparam logic [ROW_W-1:0]  ROW_MASK  =
    (ROW_SIZE_BYTES >= 8) ? {ROW_W{1'b1}} : ((ROW_W'(1) << (ROW_SIZE_BYTES * 8)) - ROW_W'(1));

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // One memory row per set: all way keys plus the round-robin pointer.
  typedef struct packed {
    logic [WAY_W-1:0]                victim;
    logic [NUM_WAYS-1:0][KEY_W-1:0]  keys;
  } set_row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_TAG,
    ST_DONE
  } cache_st_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_MLO,
    H_MHI,
    H_FOLD,
    H_DIV
  } hash_st_t;

endpackage

/* hw/rtl/sarc_hash.sv */
// Key-to-set hash: 64-bit multiplicative hash, shift-xor fold, then
// remainder by the set count (radix-16, four restoring bit steps a cycle). Uses sarc_pkg.
module sarc_hash
  import sarc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [CFG_W-1:0] divisor,
  output logic             done,
  output logic [SET_W-1:0] set_idx
);

  hash_st_t            state, state_next;
  logic [KEY_W-1:0]    key_q;
  logic [HASH_W-1:0]   prod_lo;
  logic [KEY_W-1:0]    prod_hi;
  logic [HASH_W-1:0]   dividend;
  logic [DIG_W-1:0]    digit_cnt;
  logic [KEY_W-1:0]    mul_op;
  logic [HASH_W-1:0]   mul_res;
  logic [HASH_W-1:0]   hash_sum;
  logic [SET_W-1:0]    rem_step;
  logic                last_digit;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      H_IDLE:  if (start) state_next = H_MLO;
      H_MLO:   state_next = H_MHI;
      H_MHI:   state_next = H_FOLD;
      H_FOLD:  state_next = H_DIV;
      H_DIV:   if (last_digit) state_next = H_IDLE;
      default: state_next = H_IDLE;
    endcase
  end

  // Datapath controls: one shared 32x32 multiplier
  always_comb begin
    case (state)
      H_MHI:   mul_op = HASH_MUL[HASH_W-1:KEY_W];
      default: mul_op = HASH_MUL[KEY_W-1:0];
    endcase
    last_digit = (digit_cnt == DIG_W'(DIGITS - 1));
  end

  assign mul_res  = HASH_W'(key_q) * HASH_W'(mul_op);
  assign hash_sum = prod_lo + {prod_hi, {KEY_W{1'b0}}};

  // Four restoring remainder steps per cycle
  always_comb begin
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] t;
    r = CFG_W'(set_idx);
    for (int i = 0; i < RADIX_BITS; i++) begin
      t = {r[SET_W-1:0], dividend[HASH_W-1-i]};
      if (t >= divisor) r = t - divisor;
      else              r = t;
    end
    rem_step = r[SET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == H_DIV) && last_digit;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (start) key_q <= key;
      end
      H_MLO: prod_lo <= mul_res;
      H_MHI: prod_hi <= mul_res[KEY_W-1:0];
      H_FOLD: begin
        dividend  <= hash_sum ^ (hash_sum >> HASH_SHIFT);
        set_idx   <= '0;
        digit_cnt <= '0;
      end
      H_DIV: begin
        dividend  <= dividend << RADIX_BITS;
        set_idx   <= rem_step;
        digit_cnt <= digit_cnt + DIG_W'(1);
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/set_assoc_row_cache_top.sv */
// Top level of the 8-way set-associative row cache.
// Uses sarc_pkg and sarc_hash; holds the set-row and row-data memories.
//
// Usage notes: one item is worked at a time, so a new item is taken only
// once the last one's result has gone to the output register. Each item
// passes through the hash remainder unit (low multiply, high multiply,
// fold, then the radix-16 remainder digits), then a set-row read and a
// row-data read. The result sits in an output register, so the next
// item is accepted while an earlier result is still stalled. After reset and
// after every write of cache_sets the key store is swept clean, one set per
// cycle, all 1024 sets; no item is accepted during that sweep. Writes of
// cache_sets above 1024 saturate to 1024, and zero turns the cache off
// (lookups miss, inserts are dropped). The key 0xFFFFFFFF marks an empty way,
// so it never hits and is never stored. Row data needs no sweep: a row is
// only read through a key that was written with it after the last sweep.
module set_assoc_row_cache_top
  import sarc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             command,
  input  logic [KEY_W-1:0] row_key,
  input  logic [ROW_W-1:0] row_data,
  // output channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hit,
  output logic [ROW_W-1:0] hit_data,
  output logic             written,
  output logic [CNT_W-1:0] filled_count
);

  cache_st_t          state, state_next;
  logic [CFG_W-1:0]   cache_sets;
  logic [CNT_W-1:0]   filled_total;
  logic [SET_W-1:0]   clr_cnt;

  // latched item
  logic               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [ROW_W-1:0]   data_q;
  logic               hit_q;
  logic               written_q;

  // hash unit
  logic               hash_start;
  logic               hash_done;
  logic [SET_W-1:0]   set_idx;

  // memories
  set_row_t           key_mem [MAX_SETS];
  logic [ROW_W-1:0]   row_mem [SLOTS];
  set_row_t           key_rd;
  logic [ROW_W-1:0]   row_rd;

  logic               key_we;
  logic [SET_W-1:0]   key_waddr;
  set_row_t           key_wrow;
  set_row_t           clr_row;
  set_row_t           ins_row;
  logic               row_we;
  logic [SLOT_W-1:0]  row_addr;

  // tag check
  logic [NUM_WAYS-1:0] match;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim;
  logic                cache_on;
  logic                key_ok;
  logic                found;
  logic                do_insert;
  logic                newly_filled;
  logic                out_load;
  logic [CFG_W-1:0]    sets_sat;

  assign in_stall   = (state != ST_IDLE);
  assign hash_start = (state == ST_IDLE) && in_valid;
  assign out_load   = (state == ST_DONE) && (!out_valid || !out_stall);
  assign sets_sat   = (cfg_data > CFG_W'(MAX_SETS)) ? CFG_W'(MAX_SETS) : cfg_data;

  sarc_hash u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .key     (row_key),
    .divisor (cache_sets),
    .done    (hash_done),
    .set_idx (set_idx)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == SET_W'(MAX_SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_HASH;
      ST_HASH:  if (hash_done) state_next = ST_TAG;
      ST_TAG:   state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
    if (cfg_we) state_next = ST_CLEAR;
  end

  // Tag compare on the set row read back from memory
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = (key_rd.keys[w] == key_q);
    end
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
    cache_on     = (cache_sets != '0);
    key_ok       = (key_q != EMPTY_KEY);
    found        = cache_on && key_ok && (|match);
    victim       = key_rd.victim;
    newly_filled = (key_rd.keys[victim] == EMPTY_KEY);
    do_insert    = (state == ST_TAG) && (cmd_q == CMD_INSERT) && cache_on && key_ok
                   && !(|match);
  end

  // Memory write and address selection
  always_comb begin
    clr_row.victim = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      clr_row.keys[w] = EMPTY_KEY;
    end
    ins_row              = key_rd;
    ins_row.keys[victim] = key_q;
    ins_row.victim       = victim + WAY_W'(1);

    key_we    = (state == ST_CLEAR) || do_insert;
    key_waddr = (state == ST_CLEAR) ? clr_cnt : set_idx;
    key_wrow  = (state == ST_CLEAR) ? clr_row : ins_row;

    row_we   = do_insert;
    row_addr = do_insert ? {set_idx, victim} : {set_idx, hit_way};
  end

  // Set-row memory: the read follows the hash result, which holds for the item
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wrow;
    key_rd <= key_mem[set_idx];
  end

  // Row-data memory, one port
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_addr] <= data_q;
    row_rd <= row_mem[row_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cache_sets   <= CFG_W'(MAX_SETS);
      filled_total <= '0;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cache_sets   <= sets_sat;
        filled_total <= '0;
        clr_cnt      <= '0;
      end else begin
        if (state == ST_CLEAR) clr_cnt <= clr_cnt + SET_W'(1);
        if (do_insert) filled_total <= filled_total + CNT_W'(newly_filled);
      end
      if (out_load)                   out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (hash_start) begin
      cmd_q  <= command;
      key_q  <= row_key;
      data_q <= row_data & ROW_MASK;
    end
    if (state == ST_TAG) begin
      hit_q     <= found;
      written_q <= do_insert;
    end
    if (out_load) begin
      hit          <= hit_q;
      hit_data     <= (cmd_q == CMD_LOOKUP && hit_q) ? row_rd : '0;
      written      <= written_q;
      filled_count <= filled_total;
    end
  end

endmodule

/* verif/row_cache_checker.sv */
// Checker for the set-associative row cache: predicts each reply from its
// own copy of the key store and compares accepted results in order.
// Depends on sarc_pkg for widths, hash constants and command codes.
module row_cache_checker
  import sarc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             command,
  input  logic [KEY_W-1:0] row_key,
  input  logic [ROW_W-1:0] row_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             hit,
  input  logic [ROW_W-1:0] hit_data,
  input  logic             written,
  input  logic [CNT_W-1:0] filled_count,
  output int               failures,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUE_DEPTH = 8;
  localparam int DUE_W     = $clog2(DUE_DEPTH);

  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] data;
    logic             written;
    logic [CNT_W-1:0] filled;
  } cache_reply_t;

  logic [KEY_W-1:0] key_store [SLOTS];
  logic [ROW_W-1:0] row_store [SLOTS];
  logic [WAY_W-1:0] rr_ptr [MAX_SETS];
  int unsigned      live_ways;
  int unsigned      set_count;

  // replies still owed, oldest at due_rd
  cache_reply_t     replies_due [DUE_DEPTH];
  logic [DUE_W-1:0] due_rd;
  logic [DUE_W-1:0] due_wr;
  int unsigned      due_count;

  task automatic wipe_store();
    for (int i = 0; i < SLOTS; i++) begin
      key_store[i] = EMPTY_KEY;
      row_store[i] = '0;
    end
    for (int s = 0; s < MAX_SETS; s++) rr_ptr[s] = '0;
    live_ways = 0;
  endtask

  // multiplicative hash, shift-xor fold, then reduce by the set count
  function automatic int unsigned home_set(input logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] x;
    x = HASH_W'(key) * HASH_MUL;
    x = x ^ (x >> HASH_SHIFT);
    return 32'(x % HASH_W'(set_count));
  endfunction

  function automatic cache_reply_t serve_request(input logic cmd,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [ROW_W-1:0] data);
    cache_reply_t r;
    int           found;
    int unsigned  set_idx;
    int unsigned  slot;
    r = '0;
    found = -1;
    set_idx = 0;
    if (set_count != 0 && key != EMPTY_KEY) begin
      set_idx = home_set(key);
      for (int w = 0; w < NUM_WAYS; w++)
        if (found < 0 && key_store[set_idx * NUM_WAYS + w] == key)
          found = set_idx * NUM_WAYS + w;
    end
    r.hit = (found >= 0);
    if (cmd == CMD_LOOKUP) begin
      if (found >= 0) r.data = row_store[found];
    end else if (set_count != 0 && key != EMPTY_KEY && found < 0) begin
      slot = set_idx * NUM_WAYS + rr_ptr[set_idx];
      rr_ptr[set_idx] = rr_ptr[set_idx] + 1'b1;
      if (key_store[slot] == EMPTY_KEY) live_ways++;
      key_store[slot] = key;
      row_store[slot] = data & ROW_MASK;
      r.written = 1'b1;
    end
    r.filled = CNT_W'(live_ways);
    return r;
  endfunction

  always @(posedge clk) begin
    cache_reply_t due;
    if (rst) begin
      set_count = MAX_SETS;
      wipe_store();
      due_rd    = '0;
      due_wr    = '0;
      due_count = 0;
    end else begin
      if (cfg_we) begin
        set_count = (cfg_data > MAX_SETS) ? MAX_SETS : cfg_data;
        wipe_store();
      end
      if (out_valid && !out_stall) begin
        if (due_count == 0) begin
          $display("%0t: result with no item outstanding", $time);
          $display("%0t:   hit %0b data %h written %0b filled %0d",
                   $time, hit, hit_data, written, filled_count);
          failures++;
        end else begin
          due = replies_due[due_rd];
          due_rd = due_rd + DUE_W'(1);
          due_count--;
          if (hit !== due.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, due.hit, hit);
            failures++;
          end
          if (hit_data !== due.data) begin
            $display("%0t: hit_data expected %h actual %h", $time, due.data, hit_data);
            failures++;
          end
          if (written !== due.written) begin
            $display("%0t: written expected %0b actual %0b", $time, due.written, written);
            failures++;
          end
          if (filled_count !== due.filled) begin
            $display("%0t: filled_count expected %0d actual %0d",
                     $time, due.filled, filled_count);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        due = serve_request(command, row_key, row_data);
        if (due_count == DUE_DEPTH) begin
          $display("%0t: more than %0d items outstanding", $time, DUE_DEPTH);
          failures++;
        end else begin
          replies_due[due_wr] = due;
          due_wr = due_wr + DUE_W'(1);
          due_count++;
        end
      end
    end
    pending <= int'(due_count);
  end

endmodule

/* verif/tb.sv */
// Top of the row cache testbench: clock, reset, stimulus and verdict.
// Depends on sarc_pkg, set_assoc_row_cache_top and row_cache_checker.
module tb;
  import sarc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The whole run is roughly 1550 items plus ten store sweeps;
  // the limit leaves several times what that takes.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PER_SET = 170;
  localparam int TAIL_CYCLES  = 40;
  localparam int POOL_DEPTH   = 64;
  localparam int POOL_IDX_W   = $clog2(POOL_DEPTH);

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             command = CMD_LOOKUP;
  logic [KEY_W-1:0] row_key = '0;
  logic [ROW_W-1:0] row_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             hit;
  logic [ROW_W-1:0] hit_data;
  logic             written;
  logic [CNT_W-1:0] filled_count;

  int               failures;
  int               pending;
  int unsigned      cycles = 0;
  bit               rush = 1'b0;      // both sides run with no idling
  int unsigned      stall_left = 0;
  // keys recently used, for hits and evictions; oldest at pool_head
  logic [KEY_W-1:0]      key_pool [POOL_DEPTH];
  logic [POOL_IDX_W-1:0] pool_head = '0;
  int unsigned           pool_size = 0;
  int unsigned           pool_cap = 48;

  set_assoc_row_cache_top dut (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_stall, .command, .row_key, .row_data,
    .out_valid, .out_stall, .hit, .hit_data, .written, .filled_count
  );

  row_cache_checker chk (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_stall, .command, .row_key, .row_data,
    .out_valid, .out_stall, .hit, .hit_data, .written, .filled_count,
    .failures, .pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: after taking a result, draw a random stall and spend it on
  // the next result once it shows up. Stall stays up while nothing is
  // offered, so the stall always lands on a live result.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = rush ? 0 : $urandom_range(0, 5);
      out_stall <= (stall_left != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // One item: optional gap, then hold valid and payload until taken.
  // Valid is only dropped when a gap follows, so back-to-back items never
  // see a low-then-high in the same step.
  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [ROW_W-1:0] data);
    int unsigned gap;
    gap = rush ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    row_key  <= key;
    row_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding item has produced its result.
  // The first edge lets the checker log the last accepted item.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Only called with the block idle; the block then sweeps its store.
  task automatic write_sets(input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly reuse pool keys so lookups hit and inserts collide; some extremes
  // (the empty marker, zero, largest legal key) and some fresh keys.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      sel;
    logic [KEY_W-1:0] fresh;
    sel = $urandom_range(0, 99);
    if (sel < 65 && pool_size != 0)
      return key_pool[pool_head + POOL_IDX_W'($urandom_range(0, pool_size - 1))];
    if (sel < 68) return EMPTY_KEY;
    if (sel < 70) return '0;
    if (sel < 72) return 32'hFFFF_FFFE;
    fresh = $urandom;
    key_pool[pool_head + POOL_IDX_W'(pool_size)] = fresh;
    pool_size++;
    if (pool_size > pool_cap) begin
      pool_head = pool_head + POOL_IDX_W'(1);
      pool_size--;
    end
    return fresh;
  endfunction

  task automatic random_items(input int unsigned count);
    logic cmd;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) rush = !rush;
      // let the pipe run dry now and then, and once mid-phase for sure
      if (i == count / 2 || $urandom_range(0, 59) == 0) wait_idle();
      cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP;
      send_item(cmd, pick_key(), {$urandom, $urandom});
    end
  endtask

  initial begin
    int unsigned      settings [9];
    int unsigned      eff;
    logic [KEY_W-1:0] k;

    // extremes first: one set, disabled, saturating all-ones, then five sets and the default size
    settings = '{1, 0, 2047, 5, 1024, 0, 0, 1023, 2};
    settings[5] = $urandom_range(6, 1022);
    settings[6] = $urandom_range(1025, 2046);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed run at the reset size: miss, fill, hit, duplicate insert,
    // empty-marker key, extreme keys and data patterns.
    send_item(CMD_LOOKUP, 32'h0, '0);
    send_item(CMD_INSERT, 32'h0, '0);
    send_item(CMD_LOOKUP, 32'h0, '1);
    send_item(CMD_INSERT, 32'h0, '1);
    send_item(CMD_LOOKUP, 32'h0, '0);
    send_item(CMD_INSERT, EMPTY_KEY, 64'hDEAD_BEEF_0000_FFFF);
    send_item(CMD_LOOKUP, EMPTY_KEY, '0);
    send_item(CMD_INSERT, 32'hFFFF_FFFE, '1);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFE, '0);
    send_item(CMD_INSERT, 32'h1, 64'h8000_0000_0000_0001);
    send_item(CMD_LOOKUP, 32'h1, '0);
    send_item(CMD_INSERT, 32'h1234_5678, 64'hA5A5_5A5A_A5A5_5A5A);
    send_item(CMD_LOOKUP, 32'h1234_5678, '0);
    send_item(CMD_LOOKUP, 32'h2, '0);

    foreach (settings[p]) begin
      wait_idle();
      write_sets(CFG_W'(settings[p]));
      eff = (settings[p] > MAX_SETS) ? MAX_SETS : settings[p];
      // small set counts get a pool a bit larger than the store so ways churn
      pool_cap = (eff != 0 && eff < 6) ? eff * NUM_WAYS + 4 : 48;
      pool_size = 0;
      if (p == 0) begin
        // single set: nine inserts wrap the victim pointer and evict the first
        for (int j = 0; j < NUM_WAYS + 1; j++) begin
          k = 32'd100 + j;
          send_item(CMD_INSERT, k, {$urandom, $urandom});
        end
        send_item(CMD_LOOKUP, 32'd100, '0);
        send_item(CMD_LOOKUP, 32'd108, '0);
      end
      random_items(ITEMS_PER_SET);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
